/* design/oale_pkg.sv */
// Shared types, codes and constants of the ordered array list engine.
// Used by oale_cell and ordered_array_list_engine_core; depends on nothing.
package oale_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 7;
  localparam int MODE_W    = 4;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // Byte address of the capacity_limit register.
  localparam logic [1:0] CFG_CAP_LIMIT_ADDR = 2'd0;

  // Operation codes of the input items.
  localparam logic [MODE_W-1:0] MODE_INSERT       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT_FRONT = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT_BACK  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE_FRONT = 4'd4;
  localparam logic [MODE_W-1:0] MODE_REMOVE_BACK  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SELECT       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SEARCH       = 4'd7;
  localparam logic [MODE_W-1:0] MODE_REPLACE      = 4'd8;

  // Commands broadcast to every cell of the chain.
  localparam logic [2:0] CELL_HOLD    = 3'd0;
  localparam logic [2:0] CELL_INSERT  = 3'd1;
  localparam logic [2:0] CELL_REMOVE  = 3'd2;
  localparam logic [2:0] CELL_REPLACE = 3'd3;
  localparam logic [2:0] CELL_ROTATE  = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

/* design/oale_cell.sv */
// One entry of the list: a 32-bit register that loads from its lower or upper
// neighbour, from the broadcast value, or zero, or holds. Depends on oale_pkg.
module oale_cell
  import oale_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] lower,
  input  logic [VAL_W-1:0] upper,
  output logic [VAL_W-1:0] entry
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (IDX == int'(cmd.pos)) begin
          data_nxt = cmd.value;
        end else if (IDX > int'(cmd.pos) && IDX <= int'(cmd.count)) begin
          data_nxt = lower;
        end
      end
      CELL_REMOVE: begin
        if (IDX >= int'(cmd.pos) && IDX + 1 < int'(cmd.count)) begin
          data_nxt = upper;
        end else if (IDX + 1 == int'(cmd.count)) begin
          // The entry vacated at the top of the list is cleared.
          data_nxt = '0;
        end
      end
      CELL_REPLACE: begin
        if (IDX == int'(cmd.pos)) begin
          data_nxt = cmd.value;
        end
      end
      CELL_ROTATE: begin
        data_nxt = upper;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign entry = data_r;

endmodule

/* design/ordered_array_list_engine_core.sv */
// Ordered array list engine: top level with stream ports, APB register and
// control. Depends on oale_pkg and oale_cell.
//
// The list lives in a chain of DEPTH cells, one entry per cell. Insert, remove
// and replace shift or write the whole chain together, so their result is
// offered the cycle after the input transfer and, while the output is not
// stalled, a new item may follow at once: one item per cycle. Select and
// search rotate the chain by one place per cycle for a full turn while cell 0
// is inspected, which brings every entry back to its place; no new item is
// taken until the turn is over. The store is not cleared at reset; entries at
// or above the count are never reported. An input is taken only while the
// result register is free or being emptied in the same cycle.
module ordered_array_list_engine_core
  import oale_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: mode[3:0], position[10:4], item_value[42:11]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata fields from bit 0: ok[0], read_value[32:1], found_index[39:33],
  // count[46:40], is_empty[47], is_full[48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W:0] DEPTH_LIM = (DEPTH > 127) ? (CNT_W+1)'(127) : (CNT_W+1)'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Configuration register.
  logic [CNT_W-1:0] cap_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == CFG_CAP_LIMIT_ADDR);
  assign cfg_prdata = (cfg_paddr == CFG_CAP_LIMIT_ADDR) ? {{(32-CNT_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Input fields.
  logic [MODE_W-1:0] in_mode;
  logic [CNT_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_value;
  logic              in_acc;

  assign in_mode  = in_tdata[3:0];
  assign in_pos   = in_tdata[10:4];
  assign in_value = in_tdata[42:11];

  // Control state.
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic             scan_sel_r, scan_sel_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic [VAL_W-1:0] sel_r, sel_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0] out_found_r, out_found_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_full_r, out_full_nxt;
  logic             load;

  // Chain of cells.
  cell_cmd_t        cmd;
  logic [VAL_W-1:0] data_q [DEPTH];

  logic [CNT_W-1:0] eff_cap;
  logic             last_step;
  logic             room;

  assign eff_cap   = ({1'b0, cap_r} < DEPTH_LIM) ? cap_r : DEPTH_LIM[CNT_W-1:0];
  assign room      = count_r < eff_cap;
  assign last_step = (int'(step_r) == DEPTH - 1);
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    scan_sel_nxt  = scan_sel_r;
    target_nxt    = target_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    sel_nxt       = sel_r;
    load          = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    out_found_nxt = out_found_r;
    cmd.op        = CELL_HOLD;
    cmd.pos       = in_pos;
    cmd.count     = count_r;
    cmd.value     = in_value;

    if (state_r == ST_SCAN) begin
      cmd.op   = CELL_ROTATE;
      step_nxt = step_r + STEP_W'(1);
      // Cell 0 holds the entry whose index equals the step count.
      if (scan_sel_r && int'(step_r) == int'(target_r)) begin
        sel_nxt = data_q[0];
      end
      if (!scan_sel_r && !hit_r && int'(step_r) < int'(count_r) && data_q[0] == key_r) begin
        hit_nxt   = 1'b1;
        found_nxt = CNT_W'(step_r);
      end
      if (last_step) begin
        state_nxt     = ST_IDLE;
        load          = 1'b1;
        out_ok_nxt    = 1'b1;
        out_rd_nxt    = (scan_sel_r && count_r != '0) ? sel_nxt : '0;
        out_found_nxt = scan_sel_r ? '0 : (hit_nxt ? found_nxt : count_r);
      end
    end else if (in_acc) begin
      load          = 1'b1;
      out_ok_nxt    = 1'b0;
      out_rd_nxt    = '0;
      out_found_nxt = '0;
      unique case (in_mode)
        MODE_INSERT, MODE_INSERT_FRONT, MODE_INSERT_BACK: begin
          if (in_mode == MODE_INSERT_FRONT) begin
            cmd.pos = '0;
          end else if (in_mode == MODE_INSERT_BACK) begin
            cmd.pos = count_r;
          end
          if (room && cmd.pos <= count_r) begin
            cmd.op     = CELL_INSERT;
            count_nxt  = count_r + CNT_W'(1);
            out_ok_nxt = 1'b1;
          end
        end
        MODE_REMOVE, MODE_REMOVE_FRONT, MODE_REMOVE_BACK: begin
          if (in_mode == MODE_REMOVE_FRONT) begin
            cmd.pos = '0;
          end else if (in_mode == MODE_REMOVE_BACK) begin
            cmd.pos = count_r - CNT_W'(1);
          end
          if (count_r != '0 && cmd.pos < count_r) begin
            cmd.op     = CELL_REMOVE;
            count_nxt  = count_r - CNT_W'(1);
            out_ok_nxt = 1'b1;
          end
        end
        MODE_REPLACE: begin
          if (in_pos < count_r) begin
            cmd.op     = CELL_REPLACE;
            out_ok_nxt = 1'b1;
          end
        end
        MODE_SELECT, MODE_SEARCH: begin
          load         = 1'b0;
          state_nxt    = ST_SCAN;
          step_nxt     = '0;
          scan_sel_nxt = (in_mode == MODE_SELECT);
          target_nxt   = (in_pos < count_r) ? in_pos : count_r - CNT_W'(1);
          key_nxt      = in_value;
          hit_nxt      = 1'b0;
          found_nxt    = '0;
          sel_nxt      = '0;
        end
        default: begin
          // Unused modes leave the list as it is and report failure.
          out_ok_nxt = 1'b0;
        end
      endcase
    end

    out_count_nxt = count_nxt;
    out_empty_nxt = (count_nxt == '0);
    out_full_nxt  = (count_nxt >= eff_cap);
    out_valid_nxt = (out_valid_r && !out_tready) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_sel_r <= scan_sel_nxt;
    target_r   <= target_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    sel_r      <= sel_nxt;
    if (load) begin
      out_ok_r    <= out_ok_nxt;
      out_rd_r    <= out_rd_nxt;
      out_found_r <= out_found_nxt;
      out_count_r <= out_count_nxt;
      out_empty_r <= out_empty_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      oale_cell #(
        .IDX (gi)
      ) u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .lower (data_q[(gi + DEPTH - 1) % DEPTH]),
        .upper (data_q[(gi + 1) % DEPTH]),
        .entry (data_q[gi])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_full_r, out_empty_r, out_count_r, out_found_r,
                       out_rd_r, out_ok_r};

  // The count can never outgrow the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("element count exceeds the number of cells");

  // An insert at the front with room grows the list by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_INSERT_FRONT && room) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert at front did not grow the list");

  // The count moves only after an input transfer.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !in_acc) |=> $stable(count_r))
    else $error("element count changed without an input transfer");

  // The last rotation step delivers the result and frees the input.
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && last_step) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("scan did not complete after a full rotation");

endmodule
